// ----- rtl/mbrm_pkg.sv -----
// mbrm_pkg: shared types, codes, constants and crc helper for the
// modbus read-registers master; no dependencies
`default_nettype none

package mbrm_pkg;

   // defaults and fixed constants
   localparam int          MAX_REGS_DEF = 4;
   localparam int          CNT_W        = 4;
   localparam int          STEP_W       = 3;
   localparam int          QUEUE_DEPTH  = 2;
   localparam int          CSR_IDX_W    = 2;
   localparam int          CSR_DATA_W   = 16;
   localparam logic [7:0]  FUNC_READ    = 8'h03;
   localparam logic [15:0] CRC_INIT     = 16'hFFFF;
   localparam logic [15:0] CRC_POLY     = 16'hA001;
   localparam logic [15:0] TICK_SAT     = 16'hFFFF;

   // input item kinds
   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_BYTE  = 2'd1,
      KIND_TICK  = 2'd2
   } in_kind_type;

   // result item kinds
   typedef enum logic [1:0] {
      OUT_TX    = 2'd0,
      OUT_VALUE = 2'd1,
      OUT_FAIL  = 2'd2
   } out_kind_type;

   // status codes
   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_TIMEOUT    = 3'd1,
      ST_BAD_HEADER = 3'd2,
      ST_BAD_COUNT  = 3'd3,
      ST_CRC        = 3'd4
   } status_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SLAVE_ADDR = 2'd0,
      CSR_FIRST_REG  = 2'd1,
      CSR_REG_COUNT  = 2'd2,
      CSR_TIMEOUT    = 2'd3
   } csr_index_type;

   // jobs handed from front to back
   typedef enum logic [1:0] {
      JOB_REQUEST = 2'd0,
      JOB_VALUES  = 2'd1,
      JOB_FAIL    = 2'd2
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      status_type   status;
   } job_type;

   // live configuration
   typedef struct packed {
      logic [7:0]  slave_addr;
      logic [15:0] first_register;
      logic [2:0]  register_count;
      logic [15:0] timeout_ticks;
   } cfg_type;

   // back end sequencer
   typedef enum logic [1:0] {
      BK_IDLE    = 2'd0,
      BK_REQUEST = 2'd1,
      BK_VALUES  = 2'd2
   } back_state_type;

   // crc-16/modbus update by one byte
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // register count clamped to 1..max
   function automatic logic [CNT_W-1:0] eff_count(input logic [2:0] cnt,
                                                  input logic [CNT_W-1:0] max_regs);
      logic [CNT_W-1:0] n;
      n = {1'b0, cnt};
      if (n == '0) begin
         n = {{(CNT_W-1){1'b0}}, 1'b1};
      end
      if (n > max_regs) begin
         n = max_regs;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/mbrm_if.sv -----
// mbrm_req_if / mbrm_rsp_if: valid/ready channels of the master
// depends on nothing
`default_nettype none

interface mbrm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] rx_byte;

   modport source (output valid, kind, rx_byte, input ready);
   modport sink   (input valid, kind, rx_byte, output ready);
endinterface

interface mbrm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  out_kind;
   logic [15:0] payload;
   logic [1:0]  reg_index;
   logic [2:0]  status;
   logic        last;

   modport source (output valid, out_kind, payload, reg_index, status, last, input ready);
   modport sink   (input valid, out_kind, payload, reg_index, status, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/mbrm_queue.sv -----
// mbrm_queue: short job queue between front and back
// depends on mbrm_pkg
`default_nettype none

module mbrm_queue
   import mbrm_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  job_type      push_job,
   input  wire logic    pop,
   output job_type      head_job,
   output logic         full,
   output logic         empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_QW = $clog2(DEPTH + 1);

   job_type             entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0]   count_ff,  count_in;

   assign full     = (count_ff == CNT_QW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_QW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_QW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/mbrm_front.sv -----
// mbrm_front: accepts items, tracks the reply frame, checks it and
// queues jobs; holds the register value store. depends on mbrm_pkg, mbrm_if
`default_nettype none

module mbrm_front
   import mbrm_pkg::*;
#(
   parameter int MAX_REGS = MAX_REGS_DEF,
   parameter int IDX_W    = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  cfg_type          cfg,
   mbrm_req_if.sink         req,
   output logic             push,
   output job_type          push_job,
   input  wire logic        full,
   input  wire logic        values_done,
   input  wire logic [IDX_W-1:0] rd_idx,
   output logic [15:0]      rd_data
);

   logic              awaiting_ff, awaiting_in;
   logic [4:0]        bytes_ff,    bytes_in;
   logic [15:0]       crc_ff,      crc_in;
   logic [15:0]       ticks_ff,    ticks_in;
   logic              hdr_ok_ff,   hdr_ok_in;
   logic [7:0]        count_ff,    count_in;
   logic [7:0]        crc_low_ff,  crc_low_in;
   logic [7:0]        high_ff,     high_in;
   logic              busy_ff,     busy_in;
   logic [15:0]       values_ff [MAX_REGS];

   logic              accept;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_idx;
   logic [CNT_W-1:0]  n;
   logic [5:0]        data_end;
   logic [5:0]        total;
   logic [5:0]        pos;
   logic [4:0]        off;
   logic [15:0]       limit;

   // frame geometry from the live register count
   assign n        = eff_count(cfg.register_count, CNT_W'(MAX_REGS));
   assign data_end = 6'd3 + {1'b0, n, 1'b0};
   assign total    = data_end + 6'd2;
   assign pos      = {1'b0, bytes_ff};
   assign off      = bytes_ff - 5'd3;
   assign limit    = (cfg.timeout_ticks == '0) ? 16'd1 : cfg.timeout_ticks;

   // values are held while the back end reads them out
   assign req.ready = !full && !busy_ff;
   assign accept    = req.valid && req.ready;
   assign rd_data   = values_ff[rd_idx];

   // classify the item and update the reply state
   always_comb begin
      awaiting_in = awaiting_ff;
      bytes_in    = bytes_ff;
      crc_in      = crc_ff;
      ticks_in    = ticks_ff;
      hdr_ok_in   = hdr_ok_ff;
      count_in    = count_ff;
      crc_low_in  = crc_low_ff;
      high_in     = high_ff;
      busy_in     = busy_ff;
      push        = 1'b0;
      push_job    = '{kind: JOB_REQUEST, status: ST_OK};
      wr_en       = 1'b0;
      wr_idx      = off[IDX_W:1];

      if (values_done) begin
         busy_in = 1'b0;
      end

      if (accept) begin
         case (req.kind)
            KIND_START: begin
               push        = 1'b1;
               push_job    = '{kind: JOB_REQUEST, status: ST_OK};
               awaiting_in = 1'b1;
               bytes_in    = '0;
               crc_in      = CRC_INIT;
               ticks_in    = '0;
               hdr_ok_in   = 1'b1;
               count_in    = '0;
               crc_low_in  = '0;
               high_in     = '0;
            end
            KIND_TICK: begin
               if (awaiting_ff) begin
                  if (ticks_ff != TICK_SAT) begin
                     ticks_in = ticks_ff + 16'd1;
                  end
                  if (ticks_in >= limit) begin
                     awaiting_in = 1'b0;
                     push        = 1'b1;
                     push_job    = '{kind: JOB_FAIL, status: ST_TIMEOUT};
                  end
               end
            end
            KIND_BYTE: begin
               if (awaiting_ff) begin
                  if (pos < data_end) begin
                     crc_in = crc_byte(crc_ff, req.rx_byte);
                  end
                  // field decode by byte position
                  if (pos == 6'd0) begin
                     if (req.rx_byte != cfg.slave_addr) begin
                        hdr_ok_in = 1'b0;
                     end
                  end else if (pos == 6'd1) begin
                     if (req.rx_byte != FUNC_READ) begin
                        hdr_ok_in = 1'b0;
                     end
                  end else if (pos == 6'd2) begin
                     count_in = req.rx_byte;
                  end else if (pos < data_end) begin
                     if (!off[0]) begin
                        high_in = req.rx_byte;
                     end else begin
                        wr_en = 1'b1;
                     end
                  end else if (pos == data_end) begin
                     crc_low_in = req.rx_byte;
                  end

                  bytes_in = bytes_ff + 5'd1;

                  // frame complete: run the checks in order
                  if (pos + 6'd1 >= total) begin
                     awaiting_in = 1'b0;
                     push        = 1'b1;
                     if (!hdr_ok_in) begin
                        push_job = '{kind: JOB_FAIL, status: ST_BAD_HEADER};
                     end else if (count_in != {3'b000, n, 1'b0}) begin
                        push_job = '{kind: JOB_FAIL, status: ST_BAD_COUNT};
                     end else if (crc_in != {req.rx_byte, crc_low_in}) begin
                        push_job = '{kind: JOB_FAIL, status: ST_CRC};
                     end else begin
                        push_job = '{kind: JOB_VALUES, status: ST_OK};
                        busy_in  = 1'b1;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff <= 1'b0;
         bytes_ff    <= '0;
         crc_ff      <= CRC_INIT;
         ticks_ff    <= '0;
         hdr_ok_ff   <= 1'b1;
         count_ff    <= '0;
         crc_low_ff  <= '0;
         high_ff     <= '0;
         busy_ff     <= 1'b0;
      end else begin
         awaiting_ff <= awaiting_in;
         bytes_ff    <= bytes_in;
         crc_ff      <= crc_in;
         ticks_ff    <= ticks_in;
         hdr_ok_ff   <= hdr_ok_in;
         count_ff    <= count_in;
         crc_low_ff  <= crc_low_in;
         high_ff     <= high_in;
         busy_ff     <= busy_in;
      end
   end

   // register value store, big-endian byte pairs
   always_ff @(posedge clock) begin
      if (wr_en) begin
         values_ff[wr_idx] <= {high_ff, req.rx_byte};
      end
   end

endmodule

`default_nettype wire

// ----- rtl/mbrm_back.sv -----
// mbrm_back: carries out queued jobs, one result per cycle while rsp is ready, into an
// output register; builds the request frame and its crc. depends on mbrm_pkg, mbrm_if
`default_nettype none

module mbrm_back
   import mbrm_pkg::*;
#(
   parameter int MAX_REGS = MAX_REGS_DEF,
   parameter int IDX_W    = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  cfg_type          cfg,
   input  wire logic        empty,
   input  job_type          head_job,
   output logic             pop,
   output logic             values_done,
   output logic [IDX_W-1:0] rd_idx,
   input  wire logic [15:0] rd_data,
   mbrm_rsp_if.source       rsp
);

   back_state_type     state_ff, state_in;
   logic [STEP_W-1:0]  step_ff,  step_in;
   logic [15:0]        crc_ff,   crc_in;
   logic               valid_ff, valid_in;
   logic [1:0]         kind_ff,  kind_in;
   logic [15:0]        payload_ff, payload_in;
   logic [1:0]         idx_ff,   idx_in;
   logic [2:0]         status_ff, status_in;
   logic               last_ff,  last_in;

   logic               load;
   logic [CNT_W-1:0]   n;
   logic [7:0]         tx_byte;

   assign n    = eff_count(cfg.register_count, CNT_W'(MAX_REGS));
   assign load = !valid_ff || rsp.ready;

   assign rsp.valid     = valid_ff;
   assign rsp.out_kind  = kind_ff;
   assign rsp.payload   = payload_ff;
   assign rsp.reg_index = idx_ff;
   assign rsp.status    = status_ff;
   assign rsp.last      = last_ff;

   assign rd_idx = (state_ff == BK_VALUES) ? step_ff[IDX_W-1:0] : '0;

   // request frame byte for the current step
   always_comb begin
      case (step_ff)
         3'd1:    tx_byte = FUNC_READ;
         3'd2:    tx_byte = cfg.first_register[15:8];
         3'd3:    tx_byte = cfg.first_register[7:0];
         3'd4:    tx_byte = 8'h00;
         3'd5:    tx_byte = {{(8-CNT_W){1'b0}}, n};
         3'd6:    tx_byte = crc_ff[7:0];
         3'd7:    tx_byte = crc_ff[15:8];
         default: tx_byte = cfg.slave_addr;
      endcase
   end

   // sequencer: next state and output register load
   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      crc_in      = crc_ff;
      valid_in    = valid_ff;
      kind_in     = kind_ff;
      payload_in  = payload_ff;
      idx_in      = idx_ff;
      status_in   = status_ff;
      last_in     = last_ff;
      pop         = 1'b0;
      values_done = 1'b0;

      case (state_ff)
         BK_IDLE: begin
            if (load) begin
               valid_in = 1'b0;
               if (!empty) begin
                  pop       = 1'b1;
                  valid_in  = 1'b1;
                  idx_in    = '0;
                  status_in = ST_OK;
                  case (head_job.kind)
                     JOB_REQUEST: begin
                        kind_in    = OUT_TX;
                        payload_in = {8'h00, cfg.slave_addr};
                        last_in    = 1'b0;
                        crc_in     = crc_byte(CRC_INIT, cfg.slave_addr);
                        step_in    = STEP_W'(1);
                        state_in   = BK_REQUEST;
                     end
                     JOB_VALUES: begin
                        kind_in    = OUT_VALUE;
                        payload_in = rd_data;
                        last_in    = (n == CNT_W'(1));
                        step_in    = STEP_W'(1);
                        if (n == CNT_W'(1)) begin
                           values_done = 1'b1;
                        end else begin
                           state_in = BK_VALUES;
                        end
                     end
                     default: begin
                        kind_in    = OUT_FAIL;
                        payload_in = '0;
                        status_in  = head_job.status;
                        last_in    = 1'b1;
                     end
                  endcase
               end
            end
         end
         BK_REQUEST: begin
            if (load) begin
               valid_in   = 1'b1;
               kind_in    = OUT_TX;
               payload_in = {8'h00, tx_byte};
               idx_in     = '0;
               status_in  = ST_OK;
               last_in    = (step_ff == 3'd7);
               if (step_ff < 3'd6) begin
                  crc_in = crc_byte(crc_ff, tx_byte);
               end
               step_in = step_ff + STEP_W'(1);
               if (step_ff == 3'd7) begin
                  state_in = BK_IDLE;
               end
            end
         end
         BK_VALUES: begin
            if (load) begin
               valid_in   = 1'b1;
               kind_in    = OUT_VALUE;
               payload_in = rd_data;
               idx_in     = step_ff[1:0];
               status_in  = ST_OK;
               last_in    = ({1'b0, step_ff} + CNT_W'(1) == n);
               step_in    = step_ff + STEP_W'(1);
               if ({1'b0, step_ff} + CNT_W'(1) == n) begin
                  values_done = 1'b1;
                  state_in    = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   // payload side of the output register and request crc
   always_ff @(posedge clock) begin
      crc_ff     <= crc_in;
      kind_ff    <= kind_in;
      payload_ff <= payload_in;
      idx_ff     <= idx_in;
      status_ff  <= status_in;
      last_ff    <= last_in;
   end

endmodule

`default_nettype wire

// ----- rtl/modbus_rtu_read_registers_master_top.sv -----
// modbus_rtu_read_registers_master_top: configuration registers, front,
// job queue and back. depends on mbrm_pkg, mbrm_if, mbrm_queue, mbrm_front, mbrm_back
//
//   channel    direction  handshake        carries
//   req_bus    in         valid/ready      kind, rx_byte
//   rsp_bus    out        valid/ready      out_kind, payload, reg_index, status, last
//   csr_*      in         write enable     csr_index, csr_wdata
//
// the front takes one item per cycle while req_bus.ready is high: bytes and ticks
// update the reply state in that cycle. a start gives eight transmit bytes and a
// good reply n values, one per cycle from the back while rsp_bus is ready; the
// front holds new items until the value store has been read out. a failure gives
// one status, through the job queue and the output register. reset is synchronous
// and clears all control state; no clearing pass. a stalled rsp_bus holds the
// output register; the two-entry queue then fills and req_bus.ready drops.
`default_nettype none

module modbus_rtu_read_registers_master_top
   import mbrm_pkg::*;
#(
   parameter int MAX_REGS = MAX_REGS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   mbrm_req_if.sink                   req_bus,
   mbrm_rsp_if.source                 rsp_bus,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;

   cfg_type           cfg_ff, cfg_in;
   logic              q_push;
   job_type           q_push_job;
   logic              q_pop;
   job_type           q_head;
   logic              q_full;
   logic              q_empty;
   logic              values_done;
   logic [IDX_W-1:0]  rd_idx;
   logic [15:0]       rd_data;

   // configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SLAVE_ADDR: cfg_in.slave_addr     = csr_wdata[7:0];
            CSR_FIRST_REG:  cfg_in.first_register = csr_wdata;
            CSR_REG_COUNT:  cfg_in.register_count = csr_wdata[2:0];
            CSR_TIMEOUT:    cfg_in.timeout_ticks  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{slave_addr: 8'd1, first_register: 16'd30,
                     register_count: 3'd3, timeout_ticks: 16'd500};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: item intake and reply checking
   mbrm_front #(
      .MAX_REGS (MAX_REGS),
      .IDX_W    (IDX_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req         (req_bus),
      .push        (q_push),
      .push_job    (q_push_job),
      .full        (q_full),
      .values_done (values_done),
      .rd_idx      (rd_idx),
      .rd_data     (rd_data)
   );

   // job queue
   mbrm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_push_job),
      .pop      (q_pop),
      .head_job (q_head),
      .full     (q_full),
      .empty    (q_empty)
   );

   // back: result sequencing
   mbrm_back #(
      .MAX_REGS (MAX_REGS),
      .IDX_W    (IDX_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .empty       (q_empty),
      .head_job    (q_head),
      .pop         (q_pop),
      .values_done (values_done),
      .rd_idx      (rd_idx),
      .rd_data     (rd_data),
      .rsp         (rsp_bus)
   );

   // queue never written when full nor read when empty
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("job queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("job queue underflow");

   // transmit bytes use only the low byte of the payload
   a_tx_narrow: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.out_kind == OUT_TX) |-> (rsp_bus.payload[15:8] == 8'h00))
      else $error("transmit byte wider than eight bits");

   // a failure is a single, final result with empty payload and a real code
   a_fail_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.out_kind == OUT_FAIL)
         |-> (rsp_bus.last && rsp_bus.payload == 16'h0000 && rsp_bus.status != ST_OK))
      else $error("malformed failure result");

endmodule

`default_nettype wire
